[src/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int RX_BUFFER_BYTES    = 8192;
	localparam int HEADER_BYTES       = 3;
	localparam int LENGTH_FIELD_BYTES = 2;

	// byte positions stay below the buffer size
	localparam int CNT_W   = $clog2(RX_BUFFER_BYTES);
	localparam int SIZE_W  = 17;
	localparam int INDEX_W = 13;

	localparam logic [SIZE_W-1:0] SIZE_LIMIT  = SIZE_W'(RX_BUFFER_BYTES - HEADER_BYTES);
	localparam logic [SIZE_W-1:0] HEADER_SIZE = SIZE_W'(HEADER_BYTES);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic KIND_BYTE      = 1'b0;
	localparam logic KIND_RECONNECT = 1'b1;

	localparam logic [1:0] ST_ACCEPT  = 2'd0;
	localparam logic [1:0] ST_DISCARD = 2'd1;
	localparam logic [1:0] ST_OVERRUN = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
	} item_t;

endpackage

[src/lpd_front.sv]
// ----------------------------------------------------------------------------
// lpd_front
// Input stage: accepts stream items, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module lpd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [7:0]          rx_byte,
	output logic                push,
	output lpd_pkg::item_t      push_item,
	input  logic                push_ready
);

	logic           valid_s1;
	lpd_pkg::item_t item_s1;
	logic           take;

	assign in_ready  = !valid_s1 || push_ready;
	assign take      = in_valid && in_ready;
	assign push      = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			// reconnect carries no byte
			item_s1.kind <= func ? lpd_pkg::KIND_RECONNECT : lpd_pkg::KIND_BYTE;
			item_s1.data <= func ? 8'd0 : rx_byte;
		end
	end

endmodule

[src/lpd_queue.sv]
// ----------------------------------------------------------------------------
// lpd_queue
// Short register queue between the input stage and the framing stage.
// ----------------------------------------------------------------------------
module lpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpd_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output lpd_pkg::item_t pop_item,
	input  logic           pop
);

	lpd_pkg::item_t                 slot_q [lpd_pkg::QUEUE_DEPTH];
	logic [lpd_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [lpd_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [lpd_pkg::QPTR_W:0]       fill_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = fill_q != (lpd_pkg::QPTR_W+1)'(lpd_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == lpd_pkg::QPTR_W'(lpd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == lpd_pkg::QPTR_W'(lpd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[src/lpd_back.sv]
// ----------------------------------------------------------------------------
// lpd_back
// Framing stage: tracks header and payload position and registers each result.
// ----------------------------------------------------------------------------
module lpd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	input  lpd_pkg::item_t                pop_item,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    data_byte,
	output logic [7:0]                    msg_type,
	output logic [lpd_pkg::INDEX_W-1:0]   byte_index,
	output logic                          first_of_message,
	output logic                          last_of_message,
	output logic [1:0]                    status
);

	logic [lpd_pkg::CNT_W-1:0]  count_q;
	logic [7:0]                 type_q;
	logic [7:0]                 len_low_q;
	logic [lpd_pkg::CNT_W-1:0]  size_q;
	logic                       link_down_q;
	logic                       out_valid_q;

	logic [7:0]                 data_q;
	logic [7:0]                 msg_type_q;
	logic [lpd_pkg::INDEX_W-1:0] index_q;
	logic                       first_q;
	logic                       last_q;
	logic [1:0]                 status_q;

	logic [lpd_pkg::SIZE_W-1:0] size_sum;
	logic                       overrun;
	logic [lpd_pkg::CNT_W:0]    next_pos;
	logic                       payload_last;

	assign pop = pop_valid && (!out_valid_q || out_ready);

	assign size_sum = lpd_pkg::SIZE_W'({pop_item.data, len_low_q}) +
		lpd_pkg::SIZE_W'(lpd_pkg::LENGTH_FIELD_BYTES);
	assign overrun      = size_sum > lpd_pkg::SIZE_LIMIT;
	assign next_pos     = {1'b0, count_q} + 1'b1;
	assign payload_last = next_pos >= {1'b0, size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			type_q      <= '0;
			len_low_q   <= '0;
			size_q      <= '0;
			link_down_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
				if (pop_item.kind == lpd_pkg::KIND_RECONNECT) begin
					link_down_q <= 1'b0;
					count_q     <= '0;
					type_q      <= '0;
					len_low_q   <= '0;
					size_q      <= '0;
				end else if (!link_down_q) begin
					if (count_q == lpd_pkg::CNT_W'(0)) begin
						type_q  <= pop_item.data;
						count_q <= lpd_pkg::CNT_W'(1);
					end else if (count_q == lpd_pkg::CNT_W'(1)) begin
						len_low_q <= pop_item.data;
						count_q   <= lpd_pkg::CNT_W'(2);
					end else if (count_q == lpd_pkg::CNT_W'(2)) begin
						if (overrun) begin
							link_down_q <= 1'b1;
							count_q     <= '0;
						end else begin
							size_q <= lpd_pkg::CNT_W'(size_sum);
							// lengths of zero or one end with the header
							count_q <= (size_sum <= lpd_pkg::HEADER_SIZE) ?
								'0 : lpd_pkg::CNT_W'(lpd_pkg::HEADER_BYTES);
						end
					end else begin
						count_q <= payload_last ? '0 : lpd_pkg::CNT_W'(next_pos);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q     <= pop_item.data;
			msg_type_q <= 8'd0;
			index_q    <= '0;
			first_q    <= 1'b0;
			last_q     <= 1'b0;
			status_q   <= lpd_pkg::ST_ACCEPT;
			if (pop_item.kind == lpd_pkg::KIND_RECONNECT) begin
				data_q <= 8'd0;
			end else if (link_down_q) begin
				status_q <= lpd_pkg::ST_DISCARD;
			end else begin
				index_q <= lpd_pkg::INDEX_W'(count_q);
				if (count_q == lpd_pkg::CNT_W'(0)) begin
					msg_type_q <= pop_item.data;
					first_q    <= 1'b1;
				end else if (count_q == lpd_pkg::CNT_W'(1)) begin
					msg_type_q <= type_q;
				end else if (count_q == lpd_pkg::CNT_W'(2)) begin
					msg_type_q <= type_q;
					if (overrun) begin
						status_q <= lpd_pkg::ST_OVERRUN;
					end else begin
						last_q <= size_sum <= lpd_pkg::HEADER_SIZE;
					end
				end else begin
					msg_type_q <= type_q;
					last_q     <= payload_last;
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign data_byte        = data_q;
	assign msg_type         = msg_type_q;
	assign byte_index       = index_q;
	assign first_of_message = first_q;
	assign last_of_message  = last_q;
	assign status           = status_q;

	a_overrun_drops_link: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pop_item.kind == lpd_pkg::KIND_BYTE && !link_down_q &&
		count_q == lpd_pkg::CNT_W'(2) && overrun |=> link_down_q)
		else $error("overrun did not take the link down");

	a_down_at_header: assert property (@(posedge clk) disable iff (!arst_n)
		link_down_q |-> count_q == '0)
		else $error("framing position not at header while link down");

	a_first_is_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && first_q |-> index_q == '0 && status_q == lpd_pkg::ST_ACCEPT && !last_q)
		else $error("first mark on a byte other than the type byte");

	a_discard_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != lpd_pkg::ST_ACCEPT |-> !last_q && !first_q)
		else $error("message marks on a discarded or overrun byte");

endmodule

[src/length_prefixed_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_deframer
// Splits a byte stream into type/length-prefixed messages and tags each byte.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): func selects a stream byte (0) or a
// reconnect (1); rx_byte holds the byte. Output channel (out_valid/out_ready):
// one result per input transaction, in order, carrying the byte, its message
// type, its index within the message, first/last marks and a status.
// Throughput is one transaction per cycle while out_ready stays high; the
// framing state is updated once per byte, and only receiver stalls slow it.
// An accepted item is registered in the input stage, enters the two-entry
// queue and is framed from there into the output register.
// A message larger than the receive buffer minus three bytes reports an
// overrun on its second length byte and drops the link; later bytes come out
// marked discarded until a reconnect transaction restores the link.
// Reset (arst_n low) empties the pipeline, clears the framing position and
// brings the link up. When the receiver stalls, the result holds in the output
// register, the queue fills, and then in_ready falls; no transaction is lost.
// ----------------------------------------------------------------------------
module length_prefixed_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    data_byte,
	output logic [7:0]                    msg_type,
	output logic [lpd_pkg::INDEX_W-1:0]   byte_index,
	output logic                          first_of_message,
	output logic                          last_of_message,
	output logic [1:0]                    status
);

	logic           push;
	lpd_pkg::item_t push_item;
	logic           push_ready;
	logic           pop_valid;
	lpd_pkg::item_t pop_item;
	logic           pop;

	lpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.rx_byte    (rx_byte),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	lpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	lpd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_valid        (pop_valid),
		.pop_item         (pop_item),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.data_byte        (data_byte),
		.msg_type         (msg_type),
		.byte_index       (byte_index),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.status           (status)
	);

endmodule

[dv/length_prefixed_deframer_tb.sv]
// ----------------------------------------------------------------------------
// length_prefixed_deframer_tb
// Drives stream bytes and reconnects into the deframer under random source and
// sink stalls, predicts the tagging of every byte and checks each output
// transaction in order. A directed table opens the run, then random messages,
// overruns, truncated frames and noise follow.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]                  data;
		logic [7:0]                  mtype;
		logic [lpd_pkg::INDEX_W-1:0] idx;
		logic                        first;
		logic                        last;
		logic [1:0]                  status;
	} tagged_byte_t;

	typedef struct packed {
		logic         kind;
		logic [7:0]   value;
		bit           typed;
		tagged_byte_t want;
	} stim_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         func = lpd_pkg::KIND_BYTE;
	logic [7:0]                   rx_byte = 8'h00;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [7:0]                   data_byte;
	logic [7:0]                   msg_type;
	logic [lpd_pkg::INDEX_W-1:0]  byte_index;
	logic                         first_of_message;
	logic                         last_of_message;
	logic [1:0]                   status;

	// framing state of the predictor
	logic [lpd_pkg::INDEX_W-1:0]  frame_pos = '0;
	logic [7:0]                   frame_type = '0;
	logic [7:0]                   frame_len_low = '0;
	logic [lpd_pkg::SIZE_W-1:0]   frame_size = '0;
	logic                         link_is_down = 1'b0;

	tagged_byte_t        expected_bytes[$];
	int                  mismatches = 0;
	int unsigned         src_idle_pct = 30;
	int unsigned         sink_idle_pct = 82;

	localparam int DIRECTED_ROWS = 26;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// type 0xff, length zero: ends on the last header byte
		'{lpd_pkg::KIND_BYTE, 8'hFF, 1'b1, '{8'hFF, 8'hFF, 13'd0, 1'b1, 1'b0, lpd_pkg::ST_ACCEPT}},
		'{lpd_pkg::KIND_BYTE, 8'h00, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'h00, 1'b1, '{8'h00, 8'hFF, 13'd2, 1'b0, 1'b1, lpd_pkg::ST_ACCEPT}},
		// type 0x00, length one
		'{lpd_pkg::KIND_BYTE, 8'h00, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'h01, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'h00, 1'b1, '{8'h00, 8'h00, 13'd2, 1'b0, 1'b1, lpd_pkg::ST_ACCEPT}},
		// length two: one payload byte
		'{lpd_pkg::KIND_BYTE, 8'hA5, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'h02, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'h00, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'h7E, 1'b1, '{8'h7E, 8'hA5, 13'd3, 1'b0, 1'b1, lpd_pkg::ST_ACCEPT}},
		// smallest overrun, then discarded bytes
		'{lpd_pkg::KIND_BYTE, 8'h3C, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'hFC, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'h1F, 1'b1, '{8'h1F, 8'h3C, 13'd2, 1'b0, 1'b0, lpd_pkg::ST_OVERRUN}},
		'{lpd_pkg::KIND_BYTE, 8'h55, 1'b1, '{8'h55, 8'h00, 13'd0, 1'b0, 1'b0, lpd_pkg::ST_DISCARD}},
		'{lpd_pkg::KIND_BYTE, 8'hAA, 1'b1, '{8'hAA, 8'h00, 13'd0, 1'b0, 1'b0, lpd_pkg::ST_DISCARD}},
		'{lpd_pkg::KIND_RECONNECT, 8'hFF, 1'b1, '0},
		// length 0xffff must not wrap into a small size
		'{lpd_pkg::KIND_BYTE, 8'h81, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'hFF, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'hFF, 1'b1, '{8'hFF, 8'h81, 13'd2, 1'b0, 1'b0, lpd_pkg::ST_OVERRUN}},
		'{lpd_pkg::KIND_RECONNECT, 8'h00, 1'b1, '0},
		// reconnect in the middle of a header
		'{lpd_pkg::KIND_BYTE, 8'h12, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'h05, 1'b0, '0},
		'{lpd_pkg::KIND_RECONNECT, 8'h5A, 1'b1, '0},
		'{lpd_pkg::KIND_BYTE, 8'h00, 1'b1, '{8'h00, 8'h00, 13'd0, 1'b1, 1'b0, lpd_pkg::ST_ACCEPT}},
		'{lpd_pkg::KIND_BYTE, 8'h00, 1'b0, '0},
		'{lpd_pkg::KIND_BYTE, 8'h00, 1'b1, '{8'h00, 8'h00, 13'd2, 1'b0, 1'b1, lpd_pkg::ST_ACCEPT}}
	};

	length_prefixed_deframer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.data_byte        (data_byte),
		.msg_type         (msg_type),
		.byte_index       (byte_index),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.status           (status)
	);

	always #1 clk = ~clk;

	function automatic tagged_byte_t deframe_byte(input logic kind, input logic [7:0] value);
		tagged_byte_t               r;
		logic [lpd_pkg::SIZE_W-1:0] size;
		r = '0;
		if (kind == lpd_pkg::KIND_RECONNECT) begin
			link_is_down  = 1'b0;
			frame_pos     = '0;
			frame_type    = '0;
			frame_len_low = '0;
			frame_size    = '0;
		end else if (link_is_down) begin
			r.data   = value;
			r.status = lpd_pkg::ST_DISCARD;
		end else begin
			r.data   = value;
			r.idx    = frame_pos;
			r.status = lpd_pkg::ST_ACCEPT;
			case (frame_pos)
				13'd0: begin
					frame_type = value;
					r.first    = 1'b1;
					frame_pos  = 13'd1;
				end
				13'd1: begin
					frame_len_low = value;
					frame_pos     = 13'd2;
				end
				13'd2: begin
					size       = {1'b0, value, frame_len_low} +
						lpd_pkg::SIZE_W'(lpd_pkg::LENGTH_FIELD_BYTES);
					frame_size = size;
					if (size > lpd_pkg::SIZE_LIMIT) begin
						link_is_down = 1'b1;
						frame_pos    = '0;
						r.status     = lpd_pkg::ST_OVERRUN;
					end else if (size <= lpd_pkg::HEADER_SIZE) begin
						frame_pos = '0;
						r.last    = 1'b1;
					end else begin
						frame_pos = 13'(lpd_pkg::HEADER_BYTES);
					end
				end
				default: begin
					if (lpd_pkg::SIZE_W'(frame_pos) + 1 >= frame_size) begin
						r.last    = 1'b1;
						frame_pos = '0;
					end else begin
						frame_pos = frame_pos + 1'b1;
					end
				end
			endcase
			r.mtype = frame_type;
		end
		return r;
	endfunction

	task automatic send_item(input logic kind, input logic [7:0] value, input bit typed,
			input tagged_byte_t typed_result);
		tagged_byte_t predicted;
		predicted = deframe_byte(kind, value);
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		expected_bytes.push_back(typed ? typed_result : predicted);
		in_valid <= 1'b1;
		func     <= kind;
		rx_byte  <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	// sends the first cut bytes of a frame with the given type and length
	task automatic send_frame(input logic [7:0] mtype, input logic [15:0] len,
			input int unsigned cut, inout int sent);
		logic [7:0] value;
		for (int unsigned i = 0; i < cut; i++) begin
			case (i)
				0:       value = mtype;
				1:       value = len[7:0];
				2:       value = len[15:8];
				default: value = 8'($urandom);
			endcase
			send_item(lpd_pkg::KIND_BYTE, value, 1'b0, '0);
		end
		sent += cut;
	endtask

	function automatic int unsigned frame_bytes(input logic [15:0] len);
		return (len + 2 > lpd_pkg::HEADER_BYTES) ? len + 2 : lpd_pkg::HEADER_BYTES;
	endfunction

	task automatic send_message(inout int sent);
		int unsigned pick;
		logic [15:0] len;
		logic [7:0]  mtype;
		pick  = $urandom_range(99);
		mtype = 8'($urandom);
		len   = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 24)) :
			16'($urandom_range(25, 300));
		if (pick < 70) begin
			send_frame(mtype, len, frame_bytes(len), sent);
		end else if (pick < 80) begin
			// oversized header, a few dropped bytes, then recover
			len = 16'($urandom_range(lpd_pkg::SIZE_LIMIT - 1, 65535));
			send_frame(mtype, len, lpd_pkg::HEADER_BYTES, sent);
			repeat ($urandom_range(0, 4)) begin
				send_item(lpd_pkg::KIND_BYTE, 8'($urandom), 1'b0, '0);
				sent++;
			end
			send_item(lpd_pkg::KIND_RECONNECT, 8'($urandom), 1'b0, '0);
			sent++;
		end else if (pick < 90) begin
			// truncated frame
			send_frame(mtype, len, $urandom_range(1, frame_bytes(len) - 1), sent);
			send_item(lpd_pkg::KIND_RECONNECT, 8'($urandom), 1'b0, '0);
			sent++;
		end else begin
			repeat ($urandom_range(1, 6)) begin
				send_item($urandom_range(99) < 20 ? lpd_pkg::KIND_RECONNECT :
					lpd_pkg::KIND_BYTE, 8'($urandom), 1'b0, '0);
				sent++;
			end
			send_item(lpd_pkg::KIND_RECONNECT, 8'($urandom), 1'b0, '0);
			sent++;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : monitor
		tagged_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: transaction with none expected, expected nothing, actual data %0h",
					$time, data_byte);
				mismatches++;
			end else begin
				want = expected_bytes.pop_front();
				check_field("data_byte", want.data, data_byte);
				check_field("msg_type", want.mtype, msg_type);
				check_field("byte_index", want.idx, byte_index);
				check_field("first_of_message", want.first, first_of_message);
				check_field("last_of_message", want.last, last_of_message);
				check_field("status", want.status, status);
			end
		end
	end

	initial begin : stimulus
		int sent;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].want);
		end
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct  = (phase == 0) ? 30 : (phase == 1) ? 82 : 0;
			sink_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 30 : 0;
			sent = 0;
			while (sent < 300) send_message(sent);
		end
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
